### src/sha1md_pkg.sv
// Shared types, constants and round functions for the SHA-1 digest engine.
`timescale 1ns / 1ps

package sha1md_pkg;

  // Block layout
  localparam int unsigned WordW      = 32;
  localparam int unsigned DigWords   = 5;
  localparam int unsigned WinDepth   = 16;
  localparam logic [5:0]  LenOffset  = 6'd56;
  localparam logic [5:0]  LastPos    = 6'd63;
  localparam logic [6:0]  LastRound  = 7'd79;
  localparam logic [6:0]  SchedStart = 7'd16;
  localparam logic [6:0]  Phase1     = 7'd20;
  localparam logic [6:0]  Phase2     = 7'd40;
  localparam logic [6:0]  Phase3     = 7'd60;
  localparam logic [7:0]  PadByte    = 8'h80;
  localparam logic [2:0]  LastIdx    = 3'd4;

  // Initial chaining value
  localparam logic [DigWords-1:0][WordW-1:0] Iv = '{
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  // Round constants, one per group of twenty rounds
  localparam logic [WordW-1:0] K0 = 32'h5A827999;
  localparam logic [WordW-1:0] K1 = 32'h6ED9EBA1;
  localparam logic [WordW-1:0] K2 = 32'h8F1BBCDC;
  localparam logic [WordW-1:0] K3 = 32'hCA62C1D6;

  // Input word
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
  } in_word_t;

  // Output word
  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_word_t;

  // Commands from the byte sequencer to the compression core
  typedef struct packed {
    logic              load_word;
    logic [WordW-1:0]  word;
    logic              start;
    logic              restart_chain;
  } core_ctrl_t;

  // Byte sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD_ONE,
    ST_PAD_ZERO,
    ST_PAD_LEN,
    ST_COMP,
    ST_FINAL
  } seq_state_e;

  // Compression core states
  typedef enum logic [1:0] {
    CS_IDLE,
    CS_RUN,
    CS_ADD
  } core_state_e;

  function automatic logic [WordW-1:0] rotl1(input logic [WordW-1:0] x);
    return {x[WordW-2:0], x[WordW-1]};
  endfunction

  function automatic logic [WordW-1:0] rotl5(input logic [WordW-1:0] x);
    return {x[WordW-6:0], x[WordW-1:WordW-5]};
  endfunction

  function automatic logic [WordW-1:0] rotl30(input logic [WordW-1:0] x);
    return {x[1:0], x[WordW-1:2]};
  endfunction

  // Round function selected by the round group
  function automatic logic [WordW-1:0] round_f(input logic [6:0] t,
                                               input logic [WordW-1:0] b,
                                               input logic [WordW-1:0] c,
                                               input logic [WordW-1:0] d);
    logic [WordW-1:0] r;
    if (t < Phase1) begin
      r = (b & c) | (~b & d);
    end else if (t < Phase2) begin
      r = b ^ c ^ d;
    end else if (t < Phase3) begin
      r = (b & c) | (b & d) | (c & d);
    end else begin
      r = b ^ c ^ d;
    end
    return r;
  endfunction

  function automatic logic [WordW-1:0] round_k(input logic [6:0] t);
    logic [WordW-1:0] k;
    if (t < Phase1) begin
      k = K0;
    end else if (t < Phase2) begin
      k = K1;
    end else if (t < Phase3) begin
      k = K2;
    end else begin
      k = K3;
    end
    return k;
  endfunction

endpackage

### src/sha1md_core.sv
// SHA-1 compression core: one round per cycle over a 16-word schedule shift line.
`timescale 1ns / 1ps

module sha1md_core (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  sha1md_pkg::core_ctrl_t                         ctrl_i,
  output logic                                           busy_o,
  output logic [sha1md_pkg::DigWords-1:0][sha1md_pkg::WordW-1:0] chain_o
);
  import sha1md_pkg::*;

  core_state_e state_q, state_d;
  logic [6:0]  round_q, round_d;

  logic [DigWords-1:0][WordW-1:0] chain_q;
  logic [WinDepth-1:0][WordW-1:0] win_q;
  logic [WordW-1:0] a_q, b_q, c_q, d_q, e_q;

  logic [WordW-1:0] w_cur;
  logic [WordW-1:0] mix;
  logic             shift_en;
  logic [WordW-1:0] shift_word;

  // Schedule word for this round: loaded words first, then the expansion
  always_comb begin
    if (round_q < SchedStart) begin
      w_cur = win_q[0];
    end else begin
      w_cur = rotl1(win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0]);
    end
  end

  assign mix = rotl5(a_q) + round_f(round_q, b_q, c_q, d_q) + e_q + round_k(round_q) + w_cur;

  assign shift_en   = (state_q == CS_RUN) || ctrl_i.load_word;
  assign shift_word = (state_q == CS_RUN) ? w_cur : ctrl_i.word;

  // Next state
  always_comb begin
    state_d = state_q;
    round_d = round_q;
    unique case (state_q)
      CS_IDLE: begin
        if (ctrl_i.start) begin
          state_d = CS_RUN;
          round_d = '0;
        end
      end
      CS_RUN: begin
        if (round_q == LastRound) begin
          state_d = CS_ADD;
          round_d = '0;
        end else begin
          round_d = round_q + 7'd1;
        end
      end
      CS_ADD:  state_d = CS_IDLE;
      default: state_d = CS_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    busy_o  = (state_q != CS_IDLE);
    chain_o = chain_q;
  end

  // Control and chaining state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
      round_q <= '0;
      chain_q <= Iv;
    end else begin
      state_q <= state_d;
      round_q <= round_d;
      if (ctrl_i.restart_chain) begin
        chain_q <= Iv;
      end else if (state_q == CS_ADD) begin
        chain_q[0] <= chain_q[0] + a_q;
        chain_q[1] <= chain_q[1] + b_q;
        chain_q[2] <= chain_q[2] + c_q;
        chain_q[3] <= chain_q[3] + d_q;
        chain_q[4] <= chain_q[4] + e_q;
      end
    end
  end

  // Schedule shift line and working variables
  always_ff @(posedge clk_i) begin
    if (shift_en) begin
      for (int i = 0; i < WinDepth - 1; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[WinDepth-1] <= shift_word;
    end
    if (state_q == CS_IDLE && ctrl_i.start) begin
      a_q <= chain_q[0];
      b_q <= chain_q[1];
      c_q <= chain_q[2];
      d_q <= chain_q[3];
      e_q <= chain_q[4];
    end else if (state_q == CS_RUN) begin
      a_q <= mix;
      b_q <= a_q;
      c_q <= rotl30(b_q);
      d_q <= c_q;
      e_q <= d_q;
    end
  end

endmodule

### src/sha1_message_digest.sv
// SHA-1 digest engine top level: byte packing, padding sequencer and digest output.
//
// Usage: the input channel carries one word per transfer: a message byte with a
// flag saying whether the byte is present, and an end-of-message flag. Bytes are
// packed big-endian into 64-byte blocks. The output channel returns the 160-bit
// digest as five 32-bit words, most significant first, the fifth marked last.
// A byte that neither completes a block nor ends the message is packed and the
// input stays ready. A byte that completes a block starts a compression: 80 rounds
// through the shared round unit, a chaining add and a return to the sequencer.
// An end of message writes the pad bytes up to the length field, writes the eight
// length bytes, runs one or two compressions and hands the digest to the output
// buffer; the first digest word is valid on the cycle after the handoff. No new
// byte is taken until the single round unit has finished its block; input ready is
// low while padding, compressing or handing off.
// Reset loads the initial chaining value and clears length and byte position.
// When the receiver stalls, the digest waits in a five-word output buffer and the
// next message can be taken; only the handoff of a further digest waits for it.
`timescale 1ns / 1ps

module sha1_message_digest (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  sha1md_pkg::in_word_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output sha1md_pkg::out_word_t out_data_o
);
  import sha1md_pkg::*;

  seq_state_e state_q, state_d;
  seq_state_e ret_q, ret_d;
  logic [5:0]  pos_q;
  logic [2:0]  len_cnt_q;
  logic [63:0] bit_len_q;
  logic [WordW-1:0] word_q;

  logic [DigWords-1:0][WordW-1:0] dig_q;
  logic [2:0] out_idx_q;
  logic       out_valid_q;

  logic       in_acc;
  logic       out_acc;
  logic       put_en;
  logic [7:0] put_val;
  logic       put_full;
  logic       add_len;
  logic       handoff;
  logic [2:0] len_sel;
  logic [7:0] len_byte;
  logic [4:0] lane_sh;
  logic [WordW-1:0] word_new;

  core_ctrl_t ctrl;
  logic       core_busy;
  logic [DigWords-1:0][WordW-1:0] chain;

  sha1md_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .busy_o  (core_busy),
    .chain_o (chain)
  );

  assign in_acc   = in_valid_i && in_ready_o;
  assign out_acc  = out_valid_q && out_ready_i;
  assign put_full = (pos_q == LastPos);

  // Length byte, most significant first
  assign len_sel  = 3'd7 - len_cnt_q;
  assign len_byte = bit_len_q[{len_sel, 3'b000} +: 8];

  // Byte into the word being packed: first byte overwrites, later bytes OR in
  assign lane_sh  = {~pos_q[1:0], 3'b000};
  assign word_new = (pos_q[1:0] == 2'd0) ? (32'(put_val) << lane_sh)
                                         : (word_q | (32'(put_val) << lane_sh));

  // Next state
  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_data_i.has_byte && put_full) begin
            state_d = ST_COMP;
            ret_d   = in_data_i.end_of_message ? ST_PAD_ONE : ST_IDLE;
          end else if (in_data_i.end_of_message) begin
            state_d = ST_PAD_ONE;
          end
        end
      end
      ST_PAD_ONE: begin
        if (put_full) begin
          state_d = ST_COMP;
          ret_d   = ST_PAD_ZERO;
        end else begin
          state_d = ST_PAD_ZERO;
        end
      end
      ST_PAD_ZERO: begin
        if (pos_q == LenOffset) begin
          state_d = ST_PAD_LEN;
        end else if (put_full) begin
          state_d = ST_COMP;
          ret_d   = ST_PAD_ZERO;
        end
      end
      ST_PAD_LEN: begin
        if (put_full) begin
          state_d = ST_COMP;
          ret_d   = ST_FINAL;
        end
      end
      ST_COMP: begin
        if (!core_busy) begin
          state_d = ret_q;
        end
      end
      ST_FINAL: begin
        if (!out_valid_q) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_ready_o = 1'b0;
    put_en     = 1'b0;
    put_val    = '0;
    add_len    = 1'b0;
    handoff    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        put_en     = in_valid_i && in_data_i.has_byte;
        put_val    = in_data_i.data_byte;
        add_len    = put_en;
      end
      ST_PAD_ONE: begin
        put_en  = 1'b1;
        put_val = PadByte;
      end
      ST_PAD_ZERO: begin
        put_en  = (pos_q != LenOffset);
        put_val = '0;
      end
      ST_PAD_LEN: begin
        put_en  = 1'b1;
        put_val = len_byte;
      end
      ST_COMP: begin
        put_en = 1'b0;
      end
      ST_FINAL: begin
        handoff = !out_valid_q;
      end
      default: begin
        put_en = 1'b0;
      end
    endcase
  end

  // Commands to the compression core: load word, word, start, restart chain
  assign ctrl = {put_en && (pos_q[1:0] == 2'd3), word_new, put_en && put_full, handoff};

  // Sequencer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      ret_q     <= ST_IDLE;
      pos_q     <= '0;
      len_cnt_q <= '0;
      bit_len_q <= '0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      if (put_en) begin
        pos_q <= pos_q + 6'd1;
      end
      if (put_en && state_q == ST_PAD_LEN) begin
        len_cnt_q <= len_cnt_q + 3'd1;
      end
      if (handoff) begin
        bit_len_q <= '0;
      end else if (add_len) begin
        bit_len_q <= bit_len_q + 64'd8;
      end
    end
  end

  // Partial word being packed
  always_ff @(posedge clk_i) begin
    if (put_en) begin
      word_q <= word_new;
    end
  end

  // Digest output buffer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_idx_q   <= '0;
    end else if (handoff) begin
      out_valid_q <= 1'b1;
      out_idx_q   <= '0;
    end else if (out_acc) begin
      if (out_idx_q == LastIdx) begin
        out_valid_q <= 1'b0;
      end
      out_idx_q <= out_idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (handoff) begin
      dig_q <= chain;
    end else if (out_acc) begin
      for (int i = 0; i < DigWords - 1; i++) begin
        dig_q[i] <= dig_q[i+1];
      end
    end
  end

  assign out_valid_o            = out_valid_q;
  assign out_data_o.digest_word = dig_q[0];
  assign out_data_o.word_index  = out_idx_q;
  assign out_data_o.last_word   = (out_idx_q == LastIdx);

endmodule

### src/sha1md_checker.sv
// Port-level checks for the SHA-1 digest engine, bound to the top level.
`timescale 1ns / 1ps

module sha1md_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input sha1md_pkg::in_word_t  in_data_i,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input sha1md_pkg::out_word_t out_data_o
);
  import sha1md_pkg::*;

  // A stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output word changed while stalled");

  // Last flag marks exactly the fifth word
  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.last_word == (out_data_o.word_index == LastIdx)))
    else $error("last flag does not match word index");

  // Word index stays in range
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.word_index <= LastIdx)
    else $error("word index out of range");

  // Digest words follow one another without gaps
  a_next_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_data_o.last_word |=>
      out_valid_o && out_data_o.word_index == $past(out_data_o.word_index) + 3'd1)
    else $error("digest word sequence broken");

  // End of message starts padding, so input is held off on the next cycle
  a_eom_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.end_of_message |=> !in_ready_o)
    else $error("input accepted right after end of message");

endmodule

bind sha1_message_digest sha1md_checker u_sha1md_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
